[sv/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Width and reset value of the window size register.
    localparam int          CFG_W        = 5;
    localparam logic [4:0]  WIN_SIZE_RST = 5'd5;

    // Input command codes.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Control broadcast from the top level to every cell of the sorted row.
    typedef struct packed {
        logic push;       // a sample enters the row this cycle
        logic flush;      // the row is emptied this cycle
        logic evict_en;   // the window is full, so the oldest entry leaves
    } swm_ctrl_t;

endpackage

[sv/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted row: holds a sample and its age, and on a push takes
// its own entry, a neighbor's entry or the new sample.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int AGE_W        = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swm_pkg::swm_ctrl_t             ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] evict_val,
    input  logic        [AGE_W-1:0]        last_age,
    input  logic                           in_range,
    input  logic                           left_move_right,
    input  logic signed [SAMPLE_WIDTH-1:0] left_val,
    input  logic        [AGE_W-1:0]        left_age,
    input  logic                           right_move_left,
    input  logic signed [SAMPLE_WIDTH-1:0] right_val,
    input  logic        [AGE_W-1:0]        right_age,
    output logic                           valid,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic        [AGE_W-1:0]        age,
    output logic                           evict,
    output logic                           move_right,
    output logic                           move_left
);

    logic                           valid_reg, valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg, value_next;
    logic        [AGE_W-1:0]        age_reg, age_next;
    logic                           ge_new, after_evict, stays;

    // The row is sorted by value, and among equal values by age. The new
    // sample goes in front of all equal values; the evicted entry is the
    // last of its equal values, so only larger values lie behind it.
    always_comb begin
        evict       = ctrl.evict_en && valid_reg && (age_reg == last_age);
        ge_new      = valid_reg && (value_reg >= new_sample);
        after_evict = ctrl.evict_en && valid_reg && (value_reg > evict_val);
        stays       = valid_reg && !evict && (ge_new == after_evict);
        move_right  = valid_reg && !evict && ge_new && !after_evict;
        move_left   = valid_reg && !evict && !ge_new && after_evict;
    end

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.flush) begin
            valid_next = 1'b0;
        end else if (ctrl.push) begin
            if (left_move_right) begin
                valid_next = 1'b1;
                value_next = left_val;
                age_next   = left_age + AGE_W'(1);
            end else if (stays) begin
                age_next   = age_reg + AGE_W'(1);
            end else if (right_move_left) begin
                valid_next = 1'b1;
                value_next = right_val;
                age_next   = right_age + AGE_W'(1);
            end else if (in_range) begin
                valid_next = 1'b1;
                value_next = new_sample;
                age_next   = '0;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

[sv/sliding_window_median.sv]
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median filter over the most recent window_size samples, built as a
// sorted insertion row of cells.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_        input      s_valid / s_ready    s_cmd, s_sample
//  m_        output     m_valid / m_ready    m_median, m_valid_res
//  cfg_      input      cfg_valid/cfg_ready  cfg_window_size
//
//  One input transaction is accepted per cycle while s_ready is high. The
//  cell row updates at the accepting edge and the median pick register
//  loads from the updated row once the result register is free, so the result is registered after the row update.
//  The row inserts the new sample and drops the oldest one in the same update.
//  Reset (aresetn low, synchronous) empties the row and sets window_size to 5.
//  A stalled result holds one output transaction; one more transaction may
//  be accepted behind it, then s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int WINDOW_MAX   = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_median,
    output logic                           m_valid_res,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]      cfg_window_size
);

    // Count of entries in the row, which can reach WINDOW_MAX itself.
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    // Index into the row and the age of an entry both stay below WINDOW_MAX.
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int AGE_W = IDX_W;
    // Width used to compare the register value against WINDOW_MAX.
    localparam int CMP_W = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;

    logic [swm_pkg::CFG_W-1:0] win_size_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pend_reg;
    logic                      m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] m_median_reg;
    logic                      m_valid_res_reg;

    logic [CNT_W-1:0]          n_eff;
    logic [AGE_W-1:0]          last_age;
    logic [IDX_W-1:0]          med_idx;
    logic                      s_fire, cfg_fire, out_free, full;
    swm_pkg::swm_ctrl_t        ctrl;
    logic signed [SAMPLE_WIDTH-1:0] evict_val;

    logic                           cell_valid [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
    logic        [AGE_W-1:0]        cell_age   [WINDOW_MAX];
    logic                           cell_evict [WINDOW_MAX];
    logic                           cell_mr    [WINDOW_MAX];
    logic                           cell_ml    [WINDOW_MAX];

    // A size of zero acts as one, and sizes above the row length saturate.
    always_comb begin
        if (win_size_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (CMP_W'(win_size_reg) > CMP_W'(WINDOW_MAX)) begin
            n_eff = CNT_W'(WINDOW_MAX);
        end else begin
            n_eff = CNT_W'(win_size_reg);
        end
    end

    assign last_age = AGE_W'(n_eff - CNT_W'(1));
    assign med_idx  = IDX_W'(n_eff >> 1);
    assign full     = (cnt_reg == n_eff);

    // The result register is free when empty or when its transaction leaves
    // this cycle. A pending pick may move there while a new item comes in.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !pend_reg || out_free;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        ctrl.push     = s_fire && (s_cmd == swm_pkg::CMD_PUSH) && !cfg_fire;
        ctrl.flush    = cfg_fire || (s_fire && (s_cmd == swm_pkg::CMD_CLEAR));
        ctrl.evict_en = full;
    end

    // The entry count grows on a push until the window is full, after which
    // every push evicts the oldest entry and the count stays put.
    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.flush) begin
            cnt_next = '0;
        end else if (ctrl.push && !full) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // At most one cell flags itself as the evicted entry, so an OR of the
    // gated values yields its sample.
    always_comb begin
        evict_val = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (cell_evict[i]) begin
                evict_val = evict_val | cell_value[i];
            end
        end
    end

    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        logic                           l_mr, r_ml;
        logic signed [SAMPLE_WIDTH-1:0] l_val, r_val;
        logic        [AGE_W-1:0]        l_age, r_age;

        if (j == 0) begin : g_first
            assign l_mr  = 1'b0;
            assign l_val = '0;
            assign l_age = '0;
        end else begin : g_left
            assign l_mr  = cell_mr[j-1];
            assign l_val = cell_value[j-1];
            assign l_age = cell_age[j-1];
        end

        if (j == WINDOW_MAX - 1) begin : g_last
            assign r_ml  = 1'b0;
            assign r_val = '0;
            assign r_age = '0;
        end else begin : g_right
            assign r_ml  = cell_ml[j+1];
            assign r_val = cell_value[j+1];
            assign r_age = cell_age[j+1];
        end

        swm_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH),
            .AGE_W       (AGE_W)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (ctrl),
            .new_sample     (s_sample),
            .evict_val      (evict_val),
            .last_age       (last_age),
            .in_range       (CNT_W'(j) < cnt_next),
            .left_move_right(l_mr),
            .left_val       (l_val),
            .left_age       (l_age),
            .right_move_left(r_ml),
            .right_val      (r_val),
            .right_age      (r_age),
            .valid          (cell_valid[j]),
            .value          (cell_value[j]),
            .age            (cell_age[j]),
            .evict          (cell_evict[j]),
            .move_right     (cell_mr[j]),
            .move_left      (cell_ml[j])
        );
    end

    // Configuration, entry count and the pending flag for the median pick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg <= swm_pkg::WIN_SIZE_RST;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
        end else begin
            if (cfg_fire) begin
                win_size_reg <= cfg_window_size;
            end
            cnt_reg <= cnt_next;
            if (s_fire) begin
                pend_reg <= 1'b1;
            end else if (out_free) begin
                pend_reg <= 1'b0;
            end
        end
    end

    // The median pick reads the row after its update, once the result register
    // is free. Once the window is full the median sits at index n_eff/2 of the
    // sorted row; before that the result reports zero and no valid median.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pend_reg && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (pend_reg && out_free) begin
            m_valid_res_reg <= full && cell_valid[med_idx];
            m_median_reg    <= (full && cell_valid[med_idx]) ? cell_value[med_idx] : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_median    = m_median_reg;
    assign m_valid_res = m_valid_res_reg;

endmodule

[tb/sv/sliding_window_median_tb.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Self-checking testbench for the running median filter. A scoreboard
// class keeps its own copy of the sample window, the fill count and the
// held median. It predicts one result for every accepted input
// transaction and compares each result, field by field, in arrival order.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;   // deepest window the block can hold
    localparam int SW    = 16;   // sample width in bits

    // One expected output transaction.
    typedef struct packed {
        logic signed [SW-1:0] median;
        logic                 valid_res;
    } median_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: running median predictor plus the queue of pending results.
    // ------------------------------------------------------------------------
    class median_scoreboard;
        logic [swm_pkg::CFG_W-1:0] size_reg;
        logic signed [SW-1:0] window [DEPTH];
        int unsigned          fill;
        logic signed [SW-1:0] held_median;
        logic                 held_valid;
        median_result_t       pending_medians [$];
        int unsigned          mismatches;
        int unsigned          checked;
        int unsigned          pushes;
        int unsigned          clears;
        int unsigned          size_writes;

        function new();
            size_reg    = swm_pkg::WIN_SIZE_RST;
            mismatches  = 0;
            checked     = 0;
            pushes      = 0;
            clears      = 0;
            size_writes = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (window[i]) window[i] = '0;
            fill        = 0;
            held_median = '0;
            held_valid  = 1'b0;
        endfunction

        // A register write restarts the filter from an empty window.
        function void write_size(logic [swm_pkg::CFG_W-1:0] value);
            size_reg = value;
            size_writes++;
            clear_window();
        endfunction

        // Size zero acts as one, sizes past the store depth saturate.
        function int unsigned span();
            if (size_reg == 0) return 1;
            if (size_reg > DEPTH) return DEPTH;
            return 32'(size_reg);
        endfunction

        // Value of rank k among the n newest samples; ties rank by position.
        function logic signed [SW-1:0] pick_rank(int unsigned n, int unsigned k);
            int unsigned rank;
            for (int unsigned i = 0; i < n; i++) begin
                rank = 0;
                for (int unsigned j = 0; j < n; j++) begin
                    if (window[j] < window[i] || (window[j] == window[i] && j < i)) begin
                        rank++;
                    end
                end
                if (rank == k) return window[i];
            end
            return '0;
        endfunction

        function void note_input(logic cmd, logic signed [SW-1:0] sample);
            int unsigned    n;
            median_result_t res;
            n = span();
            if (cmd == swm_pkg::CMD_CLEAR) begin
                clears++;
                clear_window();
            end else begin
                pushes++;
                for (int i = DEPTH - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = sample;
                if (fill < DEPTH) fill++;
                if (fill >= n) begin
                    held_median = pick_rank(n, n / 2);
                    held_valid  = 1'b1;
                end
            end
            res.median    = held_valid ? held_median : '0;
            res.valid_res = held_valid;
            pending_medians.push_back(res);
        endfunction

        function void check_result(logic signed [SW-1:0] median, logic valid_res);
            median_result_t exp_res;
            if (pending_medians.size() == 0) begin
                $display("%0t: unexpected result median=%0d valid_res=%0b",
                         $time, median, valid_res);
                mismatches++;
                return;
            end
            exp_res = pending_medians.pop_front();
            checked++;
            if (median !== exp_res.median) begin
                $display("%0t: median expected %0d actual %0d",
                         $time, exp_res.median, median);
                mismatches++;
            end
            if (valid_res !== exp_res.valid_res) begin
                $display("%0t: valid_res expected %0b actual %0b",
                         $time, exp_res.valid_res, valid_res);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_medians.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_cmd           = swm_pkg::CMD_PUSH;
    logic signed [SW-1:0] s_sample        = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic signed [SW-1:0] m_median;
    logic                 m_valid_res;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [swm_pkg::CFG_W-1:0] cfg_window_size = '0;

    median_scoreboard sb;

    // Idle rates in percent for the sender and the receiver.
    int send_idle = 0;
    int recv_idle = 0;

    // The main process raises this to ask the receiver for a long hold-off.
    bit hold_request = 1'b0;

    sliding_window_median #(
        .WINDOW_MAX  (DEPTH),
        .SAMPLE_WIDTH(SW)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median       (m_median),
        .m_valid_res    (m_valid_res),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_window_size(cfg_window_size)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor. Handshakes are sampled at the rising edge, where every signal
    // still holds its value from before the edge, so the order of processes
    // within the time step does not matter.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_size(cfg_window_size);
            if (s_valid && s_ready)     sb.note_input(s_cmd, s_sample);
            if (m_valid && m_ready)     sb.check_result(m_median, m_valid_res);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It drops m_ready at the current idle rate. On request it holds
    // off for a long stretch, counted here, so that the block fills up and
    // has to stall its input while the sender keeps offering transactions.
    // ------------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Each is entered just after a rising edge and returns just
    // after the edge at which its transaction was accepted. A following
    // transaction keeps s_valid high and only changes the payload, unless the sender idles first.
    // ------------------------------------------------------------------------
    task automatic offer_transaction(logic cmd, logic signed [SW-1:0] sample);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_sample <= sample;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Lower s_valid and wait until every predicted result has been checked.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // The register is written only while the block is idle.
    task automatic set_window_size(logic [swm_pkg::CFG_W-1:0] value);
        wait_results_drained();
        repeat (4) @(posedge aclk);
        cfg_valid       <= 1'b1;
        cfg_window_size <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly full-range samples, with many small values to force ties and
    // a share of the extremes.
    function automatic logic signed [SW-1:0] random_sample();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return SW'($urandom());
        if (roll < 85) return SW'($signed($urandom_range(0, 8)) - 4);
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    logic [swm_pkg::CFG_W-1:0] phase_size [12];
    int               items_sent = 0;

    initial begin
        sb = new();

        // Window sizes for the random phases: zero, the store depth, the
        // largest register value, one, two, and a mix of others.
        phase_size[0]  = 5'd0;
        phase_size[1]  = 5'd16;
        phase_size[2]  = 5'd31;
        phase_size[3]  = 5'd1;
        phase_size[4]  = 5'd2;
        phase_size[5]  = 5'd7;
        phase_size[6]  = 5'd6;
        phase_size[7]  = 5'($urandom_range(1, 16));
        phase_size[8]  = 5'($urandom_range(17, 31));
        phase_size[9]  = 5'd15;
        phase_size[10] = 5'($urandom_range(0, 31));
        phase_size[11] = 5'd4;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset size of five, with the slow receiver.
        // The first four pushes leave the window short, so valid_res stays low.
        send_idle = 12;
        recv_idle = 71;
        offer_transaction(swm_pkg::CMD_PUSH, 16'sd100);
        offer_transaction(swm_pkg::CMD_PUSH, -16'sd200);
        offer_transaction(swm_pkg::CMD_PUSH, 16'sd300);
        offer_transaction(swm_pkg::CMD_PUSH, -16'sd400);
        offer_transaction(swm_pkg::CMD_PUSH, 16'sd500);
        // Both extremes and a run of equal samples.
        offer_transaction(swm_pkg::CMD_PUSH, 16'sh8000);
        offer_transaction(swm_pkg::CMD_PUSH, 16'sh7FFF);
        offer_transaction(swm_pkg::CMD_PUSH, 16'sh7FFF);
        offer_transaction(swm_pkg::CMD_PUSH, 16'sh7FFF);
        offer_transaction(swm_pkg::CMD_PUSH, 16'sd0);
        offer_transaction(swm_pkg::CMD_PUSH, -16'sd1);
        // A clear drops the held result; a clear of an empty window too.
        offer_transaction(swm_pkg::CMD_CLEAR, 16'shFFFF);
        offer_transaction(swm_pkg::CMD_PUSH, 16'sh8000);
        offer_transaction(swm_pkg::CMD_CLEAR, 16'sd0);
        offer_transaction(swm_pkg::CMD_CLEAR, 16'sh5A5A);
        for (int i = 1; i <= 5; i++) offer_transaction(swm_pkg::CMD_PUSH, SW'(i));
        offer_transaction(swm_pkg::CMD_PUSH, 16'sd5);
        offer_transaction(swm_pkg::CMD_PUSH, 16'sd5);
        items_sent = 22;

        // Random phases. Each starts with a register write while idle, and the
        // idle pattern moves from a slow receiver to a slow sender to none.
        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                send_idle = 12;
                recv_idle = 71;
            end else if (p < 8) begin
                send_idle = 71;
                recv_idle = 12;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_window_size(phase_size[p]);

            for (int k = 0; k < 140; k++) begin
                // Back pressure: the receiver stops for a long while and the
                // block has to stall its input.
                if (p == 9 && k == 40) hold_request = 1'b1;
                // The sender pauses until the pipeline has emptied.
                if (p == 6 && k == 70) wait_results_drained();
                if ($urandom_range(0, 49) == 0) begin
                    offer_transaction(swm_pkg::CMD_CLEAR, SW'($urandom()));
                end else begin
                    offer_transaction(swm_pkg::CMD_PUSH, random_sample());
                end
                items_sent++;
            end
        end

        // Let every result arrive, then keep running so that any stray result shows up.
        wait_results_drained();
        repeat (8) @(posedge aclk);

        $display("Sent %0d transactions (%0d pushes, %0d clears) over %0d size writes.",
                 items_sent, sb.pushes, sb.clears, sb.size_writes);
        $display("Checked %0d results, including sizes zero, one, sixteen and 31.",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard limit on the run time, far past the slowest legal run.
    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_median.sv
tb/sv/sliding_window_median_tb.sv
